[rtl/core/lsf_pkg.sv]
// Shared constants, payload types and control structs for the least-squares line fit.
package lsf_pkg;

   // Build-time settings
   localparam int MAX_POINTS  = 65536;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   // Fixed field widths
   localparam int FIELD_W  = 16;
   localparam int OUT_W    = 48;
   localparam int STATUS_W = 2;

   // Derived datapath widths
   localparam int SAMPLE_W = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
   localparam int CNT_W    = $clog2(MAX_POINTS + 1);
   localparam int SX_W     = SAMPLE_W + CNT_W;
   localparam int SXX_W    = 2 * SAMPLE_W + CNT_W - 1;
   localparam int SXY_W    = 2 * SAMPLE_W + CNT_W;
   localparam int DIG_W    = 16;
   localparam int N_DIG    = (SX_W + DIG_W - 1) / DIG_W;
   localparam int KW       = (N_DIG > 1) ? $clog2(N_DIG) : 1;
   localparam int BX_W     = N_DIG * DIG_W;
   localparam int P_W      = SXY_W + DIG_W + 1;
   localparam int NUM_W    = SX_W + SXY_W + 1;
   localparam int EXT_W    = (P_W > NUM_W) ? P_W : NUM_W;
   localparam int DVD_W    = NUM_W + FRAC_BITS;
   localparam int QX_W     = ((DVD_W > OUT_W) ? DVD_W : OUT_W) + 1;
   localparam int DC_W     = $clog2(DVD_W + 1);

   // Fit status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DEGEN    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [FIELD_W-1:0] x_value;
      logic [FIELD_W-1:0] y_value;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]    slope_q16;
      logic [OUT_W-1:0]    intercept_q16;
      logic [STATUS_W-1:0] fit_status;
   } rsp_type;

   // One micro-op for the shared multiply-accumulate unit
   typedef struct packed {
      logic          en;
      logic          clear;
      logic          sub;
      logic          dsigned;
      logic [KW-1:0] k;
   } mac_op_type;

endpackage

[rtl/core/lsf_mac.sv]
// Shared digit-serial multiply-accumulate unit: wide operand times one digit per cycle while op.en is set.
module lsf_mac (
   input  logic                                   clock,
   input  lsf_pkg::mac_op_type                    op,
   input  logic signed [lsf_pkg::SXY_W-1:0]       a_operand,
   input  logic        [lsf_pkg::DIG_W-1:0]       digit,
   output logic signed [lsf_pkg::NUM_W-1:0]       acc
);

   logic signed [lsf_pkg::DIG_W:0]   digit_s;
   logic signed [lsf_pkg::P_W-1:0]   prod;
   logic signed [lsf_pkg::EXT_W-1:0] prod_ext;
   logic        [lsf_pkg::EXT_W-1:0] shifted;
   logic signed [lsf_pkg::NUM_W-1:0] term;
   logic signed [lsf_pkg::NUM_W-1:0] acc_ff;
   logic signed [lsf_pkg::NUM_W-1:0] acc_in;

   // top digit of a multiplier is signed, lower digits are plain magnitude
   assign digit_s  = {op.dsigned & digit[lsf_pkg::DIG_W-1], digit};
   assign prod     = lsf_pkg::P_W'(a_operand * digit_s);
   assign prod_ext = lsf_pkg::EXT_W'(prod);
   assign shifted  = prod_ext << (lsf_pkg::DIG_W * op.k);
   assign term     = shifted[lsf_pkg::NUM_W-1:0];

   always_comb begin
      acc_in = op.clear ? '0 : acc_ff;
      if (op.sub) begin
         acc_in = acc_in - term;
      end else begin
         acc_in = acc_in + term;
      end
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

[rtl/core/lsf_div.sv]
// Bit-serial restoring divider giving a rounded, saturated fixed-point quotient.
module lsf_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [lsf_pkg::NUM_W-1:0]   numer,
   input  logic signed [lsf_pkg::NUM_W-1:0]   denom,
   output logic                               done,
   output logic        [lsf_pkg::OUT_W-1:0]   quotient
);

   typedef enum logic [3:0] {
      D_IDLE  = 4'b0001,
      D_RUN   = 4'b0010,
      D_ROUND = 4'b0100,
      D_SAT   = 4'b1000
   } dstate_type;

   localparam int HI_W = lsf_pkg::QX_W - lsf_pkg::OUT_W + 1;

   dstate_type                      state_ff, state_in;
   logic [lsf_pkg::DC_W-1:0]        count_ff, count_in;
   logic                            neg_ff, neg_in;
   logic [lsf_pkg::DVD_W-1:0]       dvd_ff, dvd_in;
   logic [lsf_pkg::NUM_W-1:0]       rem_ff, rem_in;
   logic [lsf_pkg::NUM_W-1:0]       den_ff, den_in;
   logic [lsf_pkg::OUT_W-1:0]       quot_ff, quot_in;
   logic                            done_ff, done_in;

   logic [lsf_pkg::NUM_W-1:0]       mag;
   logic [lsf_pkg::NUM_W:0]         trial;
   logic [lsf_pkg::NUM_W:0]         diff;
   logic                            fits;
   logic                            round_up;
   logic [lsf_pkg::QX_W-1:0]        q_x;
   logic [HI_W-1:0]                 q_hi;
   logic [lsf_pkg::OUT_W-2:0]       q_lo;

   assign mag      = numer[lsf_pkg::NUM_W-1] ? lsf_pkg::NUM_W'(-numer) : numer;
   assign trial    = {rem_ff, dvd_ff[lsf_pkg::DVD_W-1]};
   assign diff     = trial - {1'b0, den_ff};
   assign fits     = ~diff[lsf_pkg::NUM_W];
   assign round_up = {rem_ff, 1'b0} >= {1'b0, den_ff};
   assign q_x      = lsf_pkg::QX_W'(dvd_ff);
   assign q_hi     = q_x[lsf_pkg::QX_W-1:lsf_pkg::OUT_W-1];
   assign q_lo     = q_x[lsf_pkg::OUT_W-2:0];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               neg_in   = numer[lsf_pkg::NUM_W-1];
               dvd_in   = lsf_pkg::DVD_W'(mag) << lsf_pkg::FRAC_BITS;
               rem_in   = '0;
               den_in   = denom;
               count_in = lsf_pkg::DC_W'(lsf_pkg::DVD_W);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in   = fits ? diff[lsf_pkg::NUM_W-1:0] : trial[lsf_pkg::NUM_W-1:0];
            dvd_in   = {dvd_ff[lsf_pkg::DVD_W-2:0], fits};
            count_in = count_ff - 1'b1;
            if (count_ff == lsf_pkg::DC_W'(1)) begin
               state_in = D_ROUND;
            end
         end
         D_ROUND: begin
            // half or more of the divisor left over: round away from zero
            if (round_up) begin
               dvd_in = dvd_ff + 1'b1;
            end
            state_in = D_SAT;
         end
         D_SAT: begin
            if (neg_ff) begin
               if ((q_hi > HI_W'(1)) || ((q_hi == HI_W'(1)) && (q_lo != '0))) begin
                  quot_in = {1'b1, {(lsf_pkg::OUT_W-1){1'b0}}};
               end else begin
                  quot_in = -q_x[lsf_pkg::OUT_W-1:0];
               end
            end else begin
               if (q_hi != '0) begin
                  quot_in = {1'b0, {(lsf_pkg::OUT_W-1){1'b1}}};
               end else begin
                  quot_in = q_x[lsf_pkg::OUT_W-1:0];
               end
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

[rtl/core/least_squares_line_fit.sv]
// Top level of the least-squares line fit: running sums, sequencer and result register.
// An ordinary point holds busy high through S_PT_XY, S_PT_XX and S_PT_ADD; the next point
// is taken only back in S_IDLE. A point marked last then runs each of the three fit terms
// through S_FIT_MUL and S_FIT_STORE, then S_DECIDE and, for a well-posed set, two divisions
// of one quotient bit per cycle, before the result strobe, which the receiver cannot stall.
// Reset (synchronous, active high) clears all sums, the count and the overflow flag.
module least_squares_line_fit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lsf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output lsf_pkg::rsp_type rsp_data
);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b0000000001,
      S_PT_XY     = 10'b0000000010,
      S_PT_XX     = 10'b0000000100,
      S_PT_ADD    = 10'b0000001000,
      S_FIT_MUL   = 10'b0000010000,
      S_FIT_STORE = 10'b0000100000,
      S_DECIDE    = 10'b0001000000,
      S_DIV_SLOPE = 10'b0010000000,
      S_DIV_ICPT  = 10'b0100000000,
      S_RESULT    = 10'b1000000000
   } state_type;

   // which cross-product difference the MAC is building
   typedef enum logic [1:0] {
      TERM_DEN   = 2'd0,
      TERM_SLOPE = 2'd1,
      TERM_ICPT  = 2'd2
   } term_type;

   state_type                                state_ff, state_in;
   term_type                                 term_ff, term_in;
   logic                                     prod_ff, prod_in;
   logic [lsf_pkg::KW-1:0]                   dig_ff, dig_in;

   // latched point
   logic signed [lsf_pkg::SAMPLE_W-1:0]      x_ff, x_in;
   logic signed [lsf_pkg::SAMPLE_W-1:0]      y_ff, y_in;
   logic                                     last_ff, last_in;

   // running sums
   logic signed [lsf_pkg::SX_W-1:0]          sum_x_ff, sum_x_in;
   logic signed [lsf_pkg::SX_W-1:0]          sum_y_ff, sum_y_in;
   logic signed [lsf_pkg::SXY_W-1:0]         sum_xy_ff, sum_xy_in;
   logic signed [lsf_pkg::SXX_W-1:0]         sum_xx_ff, sum_xx_in;
   logic [lsf_pkg::CNT_W-1:0]                count_ff, count_in;
   logic                                     ovf_ff, ovf_in;

   // fit intermediates and result
   logic signed [lsf_pkg::NUM_W-1:0]         den_ff, den_in;
   logic signed [lsf_pkg::NUM_W-1:0]         snum_ff, snum_in;
   logic signed [lsf_pkg::NUM_W-1:0]         inum_ff, inum_in;
   logic [lsf_pkg::OUT_W-1:0]                slope_ff, slope_in;
   logic [lsf_pkg::OUT_W-1:0]                icpt_ff, icpt_in;
   logic [lsf_pkg::STATUS_W-1:0]             status_ff, status_in;

   // shared units
   lsf_pkg::mac_op_type                      mac_op;
   logic signed [lsf_pkg::SXY_W-1:0]         mac_a;
   logic        [lsf_pkg::DIG_W-1:0]         mac_digit;
   logic signed [lsf_pkg::NUM_W-1:0]         mac_acc;
   logic                                     div_start;
   logic signed [lsf_pkg::NUM_W-1:0]         div_numer;
   logic                                     div_done;
   logic        [lsf_pkg::OUT_W-1:0]         div_quot;

   logic signed [lsf_pkg::SX_W-1:0]          b_sel;
   logic        [lsf_pkg::BX_W-1:0]          b_ext;
   logic        [lsf_pkg::BX_W-1:0]          b_shift;
   logic signed [lsf_pkg::SX_W-1:0]          n_signed;
   logic                                     full;
   logic                                     last_dig;
   logic                                     accept;

   assign accept   = start & ~busy;
   assign busy     = (state_ff != S_IDLE);
   assign full     = (count_ff == lsf_pkg::CNT_W'(lsf_pkg::MAX_POINTS));
   assign last_dig = (dig_ff == lsf_pkg::KW'(lsf_pkg::N_DIG - 1));
   assign n_signed = lsf_pkg::SX_W'(count_ff);

   // Operand select for the fit products:
   //   den   = n*Sxx - Sx*Sx
   //   slope = n*Sxy - Sy*Sx
   //   icpt  = Sxx*Sy - Sxy*Sx
   always_comb begin
      mac_a = '0;
      b_sel = '0;
      case (term_ff)
         TERM_DEN: begin
            mac_a = prod_ff ? lsf_pkg::SXY_W'(sum_x_ff) : lsf_pkg::SXY_W'(sum_xx_ff);
            b_sel = prod_ff ? sum_x_ff : n_signed;
         end
         TERM_SLOPE: begin
            mac_a = prod_ff ? lsf_pkg::SXY_W'(sum_y_ff) : sum_xy_ff;
            b_sel = prod_ff ? sum_x_ff : n_signed;
         end
         TERM_ICPT: begin
            mac_a = prod_ff ? sum_xy_ff : lsf_pkg::SXY_W'(sum_xx_ff);
            b_sel = prod_ff ? sum_x_ff : sum_y_ff;
         end
         default: begin
            mac_a = '0;
            b_sel = '0;
         end
      endcase
      // a point's own products bypass the fit operand select
      if (state_ff == S_PT_XY || state_ff == S_PT_XX) begin
         mac_a = lsf_pkg::SXY_W'(x_ff);
      end
   end

   assign b_ext   = lsf_pkg::BX_W'(b_sel);
   assign b_shift = b_ext >> (lsf_pkg::DIG_W * dig_ff);

   always_comb begin
      mac_op    = '0;
      mac_digit = b_shift[lsf_pkg::DIG_W-1:0];
      div_start = 1'b0;
      div_numer = snum_ff;

      state_in  = state_ff;
      term_in   = term_ff;
      prod_in   = prod_ff;
      dig_in    = dig_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      last_in   = last_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_xy_in = sum_xy_ff;
      sum_xx_in = sum_xx_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      den_in    = den_ff;
      snum_in   = snum_ff;
      inum_in   = inum_ff;
      slope_in  = slope_ff;
      icpt_in   = icpt_ff;
      status_in = status_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_in     = req_data.x_value[lsf_pkg::SAMPLE_W-1:0];
               y_in     = req_data.y_value[lsf_pkg::SAMPLE_W-1:0];
               last_in  = req_data.last_point;
               state_in = S_PT_XY;
            end
         end
         S_PT_XY: begin
            // x*y as a single signed digit
            mac_op.en      = 1'b1;
            mac_op.clear   = 1'b1;
            mac_op.dsigned = 1'b1;
            mac_digit      = lsf_pkg::DIG_W'(y_ff);
            state_in       = S_PT_XX;
         end
         S_PT_XX: begin
            mac_op.en      = 1'b1;
            mac_op.clear   = 1'b1;
            mac_op.dsigned = 1'b1;
            mac_digit      = lsf_pkg::DIG_W'(x_ff);
            if (!full) begin
               sum_xy_in = sum_xy_ff + mac_acc[lsf_pkg::SXY_W-1:0];
            end
            state_in = S_PT_ADD;
         end
         S_PT_ADD: begin
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               sum_xx_in = sum_xx_ff + mac_acc[lsf_pkg::SXX_W-1:0];
               sum_x_in  = sum_x_ff + lsf_pkg::SX_W'(x_ff);
               sum_y_in  = sum_y_ff + lsf_pkg::SX_W'(y_ff);
               count_in  = count_ff + 1'b1;
            end
            if (last_ff) begin
               term_in  = TERM_DEN;
               prod_in  = 1'b0;
               dig_in   = '0;
               state_in = S_FIT_MUL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FIT_MUL: begin
            // least significant digit first, second product subtracted
            mac_op.en      = 1'b1;
            mac_op.clear   = ~prod_ff & (dig_ff == '0);
            mac_op.sub     = prod_ff;
            mac_op.dsigned = last_dig;
            mac_op.k       = dig_ff;
            if (last_dig) begin
               dig_in = '0;
               prod_in = ~prod_ff;
               if (prod_ff) begin
                  state_in = S_FIT_STORE;
               end
            end else begin
               dig_in = dig_ff + 1'b1;
            end
         end
         S_FIT_STORE: begin
            case (term_ff)
               TERM_DEN: begin
                  den_in   = mac_acc;
                  term_in  = TERM_SLOPE;
                  state_in = S_FIT_MUL;
               end
               TERM_SLOPE: begin
                  snum_in  = mac_acc;
                  term_in  = TERM_ICPT;
                  state_in = S_FIT_MUL;
               end
               TERM_ICPT: begin
                  inum_in  = mac_acc;
                  term_in  = TERM_DEN;
                  state_in = S_DECIDE;
               end
               default: begin
                  term_in  = TERM_DEN;
                  state_in = S_DECIDE;
               end
            endcase
         end
         S_DECIDE: begin
            slope_in = '0;
            icpt_in  = '0;
            if (ovf_ff) begin
               status_in = lsf_pkg::ST_OVERFLOW;
               state_in  = S_RESULT;
            end else if ((count_ff < lsf_pkg::CNT_W'(2)) || den_ff[lsf_pkg::NUM_W-1]
                         || (den_ff == '0)) begin
               status_in = lsf_pkg::ST_DEGEN;
               state_in  = S_RESULT;
            end else begin
               status_in = lsf_pkg::ST_OK;
               div_start = 1'b1;
               state_in  = S_DIV_SLOPE;
            end
         end
         S_DIV_SLOPE: begin
            // divider is idle again on its done cycle: chain the intercept at once
            if (div_done) begin
               slope_in  = div_quot;
               div_numer = inum_ff;
               div_start = 1'b1;
               state_in  = S_DIV_ICPT;
            end
         end
         S_DIV_ICPT: begin
            if (div_done) begin
               icpt_in  = div_quot;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            // result on the ports this cycle; start a fresh set
            sum_x_in  = '0;
            sum_y_in  = '0;
            sum_xy_in = '0;
            sum_xx_in = '0;
            count_in  = '0;
            ovf_in    = 1'b0;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         term_ff   <= TERM_DEN;
         prod_ff   <= 1'b0;
         dig_ff    <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xy_ff <= '0;
         sum_xx_ff <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         term_ff   <= term_in;
         prod_ff   <= prod_in;
         dig_ff    <= dig_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_xy_ff <= sum_xy_in;
         sum_xx_ff <= sum_xx_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      last_ff   <= last_in;
      den_ff    <= den_in;
      snum_ff   <= snum_in;
      inum_ff   <= inum_in;
      slope_ff  <= slope_in;
      icpt_ff   <= icpt_in;
      status_ff <= status_in;
   end

   lsf_mac u_mac (
      .clock     (clock),
      .op        (mac_op),
      .a_operand (mac_a),
      .digit     (mac_digit),
      .acc       (mac_acc)
   );

   lsf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (den_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // result transfer straight from flops
   assign rsp_strobe             = (state_ff == S_RESULT);
   assign rsp_data.slope_q16     = slope_ff;
   assign rsp_data.intercept_q16 = icpt_ff;
   assign rsp_data.fit_status    = status_ff;

endmodule

[rtl/core/lsf_checker.sv]
// Port-level checks on the line fit, bound to the top level.
module lsf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input lsf_pkg::rsp_type rsp_data
);

   // busy is high in the cycle after an accepted point
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a point transfer");

   // a result transfer lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // results only appear while the block is working on a set
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // failed fits carry zero slope and intercept
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.fit_status != lsf_pkg::ST_OK))
         |-> ((rsp_data.slope_q16 == '0) && (rsp_data.intercept_q16 == '0)))
      else $error("non-zero fit fields with a failure status");

   // status is one of the three defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.fit_status == lsf_pkg::ST_OK)
                      || (rsp_data.fit_status == lsf_pkg::ST_DEGEN)
                      || (rsp_data.fit_status == lsf_pkg::ST_OVERFLOW)))
      else $error("undefined fit status code");

endmodule

bind least_squares_line_fit lsf_checker u_lsf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
